>>> rtl/core/hnif_pkg.sv
// Shared types and constants for the hopping neighbour index finder.
// Used by every module of the block but the port checker; no dependencies of its own.
`default_nettype none
package hnif_pkg;

  localparam int TABLE_DEPTH_DEF = 4096;
  localparam int MAX_SITES_DEF   = 32;

  localparam int POS_W    = 12;
  localparam int WORD_W   = 32;
  localparam int IDX_W    = 25;
  localparam int WEIGHT_W = 16;
  localparam int SITES_W  = 6;
  localparam int SITE_W   = 5;
  localparam int COUNT_W  = 13;
  localparam int OFFSET_W = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [SITES_W-1:0]  NUM_SITES_RST = 6'd32;
  localparam logic [COUNT_W-1:0]  ENTRIES_RST   = 13'd4096;
  localparam logic [OFFSET_W-1:0] OFFSET_RST    = 24'd0;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST    = 16'sd8192;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_SITES,
    CFG_ENTRIES,
    CFG_OFFSET,
    CFG_WEIGHT
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_WAIT,
    ST_SCAN,
    ST_PROBE,
    ST_CMP,
    ST_FLUSH
  } seq_state_t;

  typedef struct packed {
    logic diag;
    logic push;
    logic flush;
  } emit_ctl_t;

endpackage
`default_nettype wire

>>> rtl/core/hopping_neighbor_index_finder_top.sv
// Top level of the hopping neighbour index finder: configuration registers,
// basis table, query sequencer and result stage. Uses hnif_pkg.
//
// A load word writes one table slot at the accepting edge and leaves busy low.
// A query raises busy and produces its column: the diagonal entry first, then
// one entry per neighbour found, the final one flagged by last_entry. Each
// result is on the ports for one cycle under strobe and cannot be held off;
// strobes never come in consecutive cycles. The table has one read port, so a
// query reads the queried word and scans the site pairs in turn, running a
// binary search of at most ceil(log2(entries+1)) probes for each pair with
// differing bits. The final result appears in the cycle busy falls.
`default_nettype none
module hopping_neighbor_index_finder_top #(
  parameter int TABLE_DEPTH = hnif_pkg::TABLE_DEPTH_DEF,
  parameter int MAX_SITES   = hnif_pkg::MAX_SITES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              action,
  input  wire logic [hnif_pkg::POS_W-1:0]        table_position,
  input  wire logic [hnif_pkg::WORD_W-1:0]       basis_word,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [hnif_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [hnif_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                                   strobe,
  output logic      [hnif_pkg::IDX_W-1:0]        row_index,
  output logic      [hnif_pkg::IDX_W-1:0]        column_index,
  output logic signed [hnif_pkg::WEIGHT_W-1:0]   entry_weight,
  output logic                                   last_entry
);
  import hnif_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int NW = $clog2(TABLE_DEPTH + 1);
  localparam int CW = (NW > COUNT_W) ? NW : COUNT_W;

  logic [SITES_W-1:0]         num_sites;
  logic [COUNT_W-1:0]         entries_in_use;
  logic [OFFSET_W-1:0]        index_offset;
  logic signed [WEIGHT_W-1:0] hop_weight;

  logic [CW-1:0]     ent_ext;
  logic [NW-1:0]     n_eff;
  logic [SITES_W-1:0] sites;
  logic              wr_en, rd_en;
  logic [AW-1:0]     rd_addr, match_idx;
  logic [WORD_W-1:0] rd_data;
  emit_ctl_t         ectl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_sites      <= NUM_SITES_RST;
      entries_in_use <= ENTRIES_RST;
      index_offset   <= OFFSET_RST;
      hop_weight     <= WEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_NUM_SITES: num_sites      <= cfg_data[SITES_W-1:0];
        CFG_ENTRIES:   entries_in_use <= cfg_data[COUNT_W-1:0];
        CFG_OFFSET:    index_offset   <= cfg_data[OFFSET_W-1:0];
        CFG_WEIGHT:    hop_weight     <= cfg_data[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  assign ent_ext = CW'(entries_in_use);
  assign n_eff   = (ent_ext > CW'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH) : NW'(ent_ext);
  assign sites   = (num_sites > SITES_W'(MAX_SITES)) ? SITES_W'(MAX_SITES) : num_sites;
  assign wr_en   = start && !busy && !action
                   && (32'(table_position) < 32'(TABLE_DEPTH));

  hnif_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(table_position)),
    .wr_data (basis_word),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  hnif_seq #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW),
    .NW          (NW)
  ) u_seq (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .action         (action),
    .table_position (table_position),
    .n_eff          (n_eff),
    .sites          (sites),
    .rd_data        (rd_data),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .busy           (busy),
    .ectl           (ectl),
    .match_idx      (match_idx)
  );

  hnif_emit #(
    .AW (AW)
  ) u_emit (
    .clk          (clk),
    .rst          (rst),
    .ectl         (ectl),
    .diag_pos     (table_position),
    .match_idx    (match_idx),
    .index_offset (index_offset),
    .hop_weight   (hop_weight),
    .strobe       (strobe),
    .row_index    (row_index),
    .column_index (column_index),
    .entry_weight (entry_weight),
    .last_entry   (last_entry)
  );

endmodule
`default_nettype wire

>>> rtl/core/hnif_table.sv
// Basis table: single write port, single read port, registered read data.
// Depends on hnif_pkg for the word width.
`default_nettype none
module hnif_table #(
  parameter int TABLE_DEPTH = hnif_pkg::TABLE_DEPTH_DEF,
  parameter int AW = $clog2(TABLE_DEPTH)
) (
  input  wire logic                      clk,
  input  wire logic                      wr_en,
  input  wire logic [AW-1:0]             wr_addr,
  input  wire logic [hnif_pkg::WORD_W-1:0] wr_data,
  input  wire logic                      rd_en,
  input  wire logic [AW-1:0]             rd_addr,
  output logic      [hnif_pkg::WORD_W-1:0] rd_data
);
  import hnif_pkg::*;

  logic [WORD_W-1:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/hnif_seq.sv
// Query sequencer: reads the queried word, scans site pairs and runs one
// binary search per hopping neighbour over the basis table. Uses hnif_pkg.
`default_nettype none
module hnif_seq #(
  parameter int TABLE_DEPTH = hnif_pkg::TABLE_DEPTH_DEF,
  parameter int AW = $clog2(TABLE_DEPTH),
  parameter int NW = $clog2(TABLE_DEPTH + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic                          action,
  input  wire logic [hnif_pkg::POS_W-1:0]    table_position,
  input  wire logic [NW-1:0]                 n_eff,
  input  wire logic [hnif_pkg::SITES_W-1:0]  sites,
  input  wire logic [hnif_pkg::WORD_W-1:0]   rd_data,
  output logic                               rd_en,
  output logic      [AW-1:0]                 rd_addr,
  output logic                               busy,
  output hnif_pkg::emit_ctl_t                ectl,
  output logic      [AW-1:0]                 match_idx
);
  import hnif_pkg::*;

  seq_state_t        state, state_next;
  logic [POS_W-1:0]  pos_q;
  logic [WORD_W-1:0] basis;
  logic [WORD_W-1:0] key;
  logic [SITE_W-1:0] s;
  logic [NW-1:0]     lo, hi1;
  logic [NW-1:0]     lo_n, hi1_n;
  logic [NW-1:0]     plo, phi1;
  logic [NW:0]       msum;
  logic [AW-1:0]     mid, mid_q;
  logic              hit, less, pos_ok, pair_end, pair_diff, range_ok;

  assign hit       = (rd_data == key);
  assign less      = (rd_data < key);
  assign pos_ok    = (32'(table_position) < 32'(n_eff));
  assign pair_end  = (({1'b0, s} + 6'd1) >= sites);
  assign pair_diff = (basis[s] != basis[s + 5'd1]);
  assign match_idx = mid_q;

  always_comb begin
    lo_n  = lo;
    hi1_n = hi1;
    if (less) begin
      lo_n = NW'(mid_q) + NW'(1);
    end else begin
      hi1_n = NW'(mid_q);
    end
    if (state == ST_CMP) begin
      plo  = lo_n;
      phi1 = hi1_n;
    end else begin
      plo  = lo;
      phi1 = hi1;
    end
    msum     = (NW+1)'(plo) + (NW+1)'(phi1) - (NW+1)'(1);
    mid      = AW'(msum[NW:1]);
    range_ok = (plo < phi1);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start && action) begin
          state_next = pos_ok ? ST_RD : ST_FLUSH;
        end
      end
      ST_RD:   state_next = ST_WAIT;
      ST_WAIT: state_next = ST_SCAN;
      ST_SCAN: begin
        if (pair_end) begin
          state_next = ST_FLUSH;
        end else if (pair_diff) begin
          state_next = ST_PROBE;
        end
      end
      ST_PROBE: state_next = range_ok ? ST_CMP : ST_SCAN;
      ST_CMP: begin
        if (hit || !range_ok) begin
          state_next = ST_SCAN;
        end
      end
      ST_FLUSH: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy       = (state != ST_IDLE);
    rd_en      = 1'b0;
    rd_addr    = mid;
    ectl.diag  = 1'b0;
    ectl.push  = 1'b0;
    ectl.flush = 1'b0;
    case (state)
      ST_IDLE:  ectl.diag = start && action;
      ST_RD: begin
        rd_en   = 1'b1;
        rd_addr = AW'(pos_q);
      end
      ST_PROBE: rd_en = range_ok;
      ST_CMP: begin
        ectl.push = hit;
        rd_en     = !hit && range_ok;
      end
      ST_FLUSH: ectl.flush = 1'b1;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: pos_q <= table_position;
      ST_WAIT: begin
        basis <= rd_data;
        s     <= '0;
      end
      ST_SCAN: begin
        if (!pair_end) begin
          if (pair_diff) begin
            key <= basis ^ (32'd3 << s);
            lo  <= '0;
            hi1 <= n_eff;
          end else begin
            s <= s + 5'd1;
          end
        end
      end
      ST_PROBE: begin
        if (range_ok) begin
          mid_q <= mid;
        end else begin
          s <= s + 5'd1;
        end
      end
      ST_CMP: begin
        if (hit || !range_ok) begin
          s <= s + 5'd1;
        end else begin
          lo    <= lo_n;
          hi1   <= hi1_n;
          mid_q <= mid;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/core/hnif_emit.sv
// Result stage: holds one pending entry so that the final one can carry the
// last flag, and drives the registered result ports. Uses hnif_pkg.
`default_nettype none
module hnif_emit #(
  parameter int AW = 12
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire hnif_pkg::emit_ctl_t             ectl,
  input  wire logic [hnif_pkg::POS_W-1:0]      diag_pos,
  input  wire logic [AW-1:0]                   match_idx,
  input  wire logic [hnif_pkg::OFFSET_W-1:0]   index_offset,
  input  wire logic signed [hnif_pkg::WEIGHT_W-1:0] hop_weight,
  output logic                                 strobe,
  output logic      [hnif_pkg::IDX_W-1:0]      row_index,
  output logic      [hnif_pkg::IDX_W-1:0]      column_index,
  output logic signed [hnif_pkg::WEIGHT_W-1:0] entry_weight,
  output logic                                 last_entry
);
  import hnif_pkg::*;

  logic [IDX_W-1:0]           col, pend_row, diag_idx, match_row;
  logic signed [WEIGHT_W-1:0] pend_w;

  assign diag_idx  = IDX_W'(diag_pos) + IDX_W'(index_offset);
  assign match_row = IDX_W'(match_idx) + IDX_W'(index_offset);

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= ectl.push || ectl.flush;
    end
  end

  always_ff @(posedge clk) begin
    if (ectl.diag) begin
      col      <= diag_idx;
      pend_row <= diag_idx;
      pend_w   <= '0;
    end
    if (ectl.push) begin
      pend_row <= match_row;
      pend_w   <= hop_weight;
    end
    if (ectl.push || ectl.flush) begin
      row_index    <= pend_row;
      column_index <= col;
      entry_weight <= pend_w;
      last_entry   <= ectl.flush;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/hnif_chk.sv
// Port-level checker for the hopping neighbour index finder, bound to the top.
// Watches only the handshake and flag ports; no package dependency.
`default_nettype none
module hnif_chk (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic action,
  input wire logic strobe,
  input wire logic last_entry
);

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && action |=> busy)
    else $error("query word did not raise busy");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    start && !busy && !action |=> !busy)
    else $error("load word raised busy");

  a_strobe_in_query: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("result outside a query");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> strobe && last_entry)
    else $error("query ended without its last word");

  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_entry |-> busy)
    else $error("non-final word after the query ended");

endmodule

bind hopping_neighbor_index_finder_top hnif_chk u_chk (.*);
`default_nettype wire

>>> tb/tb_hopping_neighbor_index_finder_top.sv
// Testbench for hopping_neighbor_index_finder_top: loads basis tables, runs
// neighbour queries and checks every matrix entry against an in-bench predictor.
// Depends on hnif_pkg and the top-level RTL only.
`default_nettype none
module tb_hopping_neighbor_index_finder_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hnif_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int CFG_SETTLE  = 4;
  localparam int TAIL_CYCLES = 500;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  typedef struct packed {
    logic [IDX_W-1:0]    row;
    logic [IDX_W-1:0]    col;
    logic [WEIGHT_W-1:0] weight;
    logic                last;
  } matrix_entry_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic action = 1'b0;
  logic [POS_W-1:0] table_position = '0;
  logic [WORD_W-1:0] basis_word = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic strobe;
  logic [IDX_W-1:0] row_index;
  logic [IDX_W-1:0] column_index;
  logic signed [WEIGHT_W-1:0] entry_weight;
  logic last_entry;

  // predictor state
  logic [WORD_W-1:0]   basis_copy [TABLE_DEPTH_DEF];
  bit                  slot_loaded [TABLE_DEPTH_DEF];
  logic [WORD_W-1:0]   full_prefix = '0;
  logic [SITES_W-1:0]  cfg_sites   = NUM_SITES_RST;
  logic [COUNT_W-1:0]  cfg_entries = ENTRIES_RST;
  logic [OFFSET_W-1:0] cfg_offset  = OFFSET_RST;
  logic [WEIGHT_W-1:0] cfg_weight  = WEIGHT_RST;

  matrix_entry_t pending_entries[$];
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  bit no_gaps = 1'b0;

  hopping_neighbor_index_finder_top u_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .action         (action),
    .table_position (table_position),
    .basis_word     (basis_word),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .strobe         (strobe),
    .row_index      (row_index),
    .column_index   (column_index),
    .entry_weight   (entry_weight),
    .last_entry     (last_entry)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < TABLE_DEPTH_DEF; i++) begin
      basis_copy[i] = '0;
      slot_loaded[i] = 1'b0;
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Build the column for one query: diagonal first, then each neighbour found.
  task automatic predict_column(input logic [POS_W-1:0] pos);
    matrix_entry_t column_q[$];
    matrix_entry_t e;
    logic [COUNT_W-1:0] n;
    logic [WORD_W-1:0] st, key;
    logic [IDX_W-1:0] col;
    int sites, lo, hi, mid, hit;
    n = (cfg_entries > COUNT_W'(TABLE_DEPTH_DEF)) ? COUNT_W'(TABLE_DEPTH_DEF) : cfg_entries;
    col = IDX_W'(pos) + IDX_W'(cfg_offset);
    e.row = col;
    e.col = col;
    e.weight = '0;
    e.last = 1'b0;
    column_q = {column_q, e};
    if (pos < n) begin
      sites = (cfg_sites > MAX_SITES_DEF) ? MAX_SITES_DEF : int'(cfg_sites);
      st = basis_copy[pos];
      for (int s = 0; s + 1 < sites; s++) begin
        if (st[s] != st[s+1]) begin
          key = st ^ (32'd3 << s);
          hit = -1;
          lo = 0;
          hi = int'(n) - 1;
          while (lo <= hi && hit < 0) begin
            mid = lo + (hi - lo) / 2;
            if (basis_copy[mid] == key) hit = mid;
            else if (basis_copy[mid] < key) lo = mid + 1;
            else hi = mid - 1;
          end
          if (hit >= 0) begin
            e.row = IDX_W'(hit) + IDX_W'(cfg_offset);
            e.weight = cfg_weight;
            column_q = {column_q, e};
          end
        end
      end
    end
    column_q[column_q.size() - 1].last = 1'b1;
    foreach (column_q[i]) pending_entries = {pending_entries, column_q[i]};
  endtask

  task automatic send_item(input action_t act, input logic [POS_W-1:0] pos,
                           input logic [WORD_W-1:0] word);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    action <= act;
    table_position <= pos;
    basis_word <= word;
    do @(posedge clk); while (busy);
    if (act == ACT_LOAD) begin
      basis_copy[pos] = word;
      slot_loaded[pos] = 1'b1;
    end else begin
      predict_column(pos);
    end
  endtask

  // Load every slot that the query and its neighbour searches will read, then query.
  task automatic query_full(input logic [POS_W-1:0] pos);
    logic [COUNT_W-1:0] n;
    logic [WORD_W-1:0] st, key;
    int sites, lo, hi, mid, hit;
    n = (cfg_entries > COUNT_W'(TABLE_DEPTH_DEF)) ? COUNT_W'(TABLE_DEPTH_DEF) : cfg_entries;
    if (pos < n) begin
      if (!slot_loaded[pos])
        send_item(ACT_LOAD, pos, {full_prefix[WORD_W-POS_W-1:0], pos});
      sites = (cfg_sites > MAX_SITES_DEF) ? MAX_SITES_DEF : int'(cfg_sites);
      st = basis_copy[pos];
      for (int s = 0; s + 1 < sites; s++) begin
        if (st[s] != st[s+1]) begin
          key = st ^ (32'd3 << s);
          hit = -1;
          lo = 0;
          hi = int'(n) - 1;
          while (lo <= hi && hit < 0) begin
            mid = lo + (hi - lo) / 2;
            if (!slot_loaded[mid])
              send_item(ACT_LOAD, POS_W'(mid),
                        {full_prefix[WORD_W-POS_W-1:0], POS_W'(mid)});
            if (basis_copy[mid] == key) hit = mid;
            else if (basis_copy[mid] < key) lo = mid + 1;
            else hi = mid - 1;
          end
        end
      end
    end
    send_item(ACT_QUERY, pos, $urandom);
  endtask

  // Hold start low until every entry is back and the block is idle.
  task automatic drain(input int settle);
    @(negedge clk);
    start <= 1'b0;
    while (pending_entries.size() != 0 || busy) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    logic [CFG_DATA_W-1:0] keep, junk;
    case (idx)
      CFG_NUM_SITES: keep = (32'd1 << SITES_W) - 1;
      CFG_ENTRIES:   keep = (32'd1 << COUNT_W) - 1;
      CFG_OFFSET:    keep = (32'd1 << OFFSET_W) - 1;
      default:       keep = (32'd1 << WEIGHT_W) - 1;
    endcase
    junk = ($urandom_range(0, 1) == 1) ? ($urandom & ~keep) : '0;
    drain(CFG_SETTLE);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= (value & keep) | junk;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_NUM_SITES: cfg_sites = value[SITES_W-1:0];
      CFG_ENTRIES:   cfg_entries = value[COUNT_W-1:0];
      CFG_OFFSET:    cfg_offset = value[OFFSET_W-1:0];
      default:       cfg_weight = value[WEIGHT_W-1:0];
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic report_mismatch(input string what, input matrix_entry_t want,
                                 input matrix_entry_t seen);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t %s: expected row %0d col %0d weight %0d last %0b, got row %0d col %0d weight %0d last %0b",
               $realtime, what, want.row, want.col, $signed(want.weight), want.last,
               seen.row, seen.col, $signed(seen.weight), seen.last);
  endtask

  always @(posedge clk) begin : check_entries
    matrix_entry_t seen, want;
    if (!rst && strobe) begin
      seen.row = row_index;
      seen.col = column_index;
      seen.weight = entry_weight;
      seen.last = last_entry;
      if (pending_entries.size() == 0) begin
        report_mismatch("unexpected word", '0, seen);
      end else begin
        want = pending_entries.pop_front();
        if (seen.row !== want.row || seen.col !== want.col ||
            seen.weight !== want.weight || seen.last !== want.last)
          report_mismatch("mismatch", want, seen);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // Four-site half-filled basis, then the corner settings on it.
  task automatic test_directed_small_table();
    logic [WORD_W-1:0] states [6] = '{32'd3, 32'd5, 32'd6, 32'd9, 32'd10, 32'd12};
    write_reg(CFG_NUM_SITES, 32'd4);
    write_reg(CFG_ENTRIES, 32'd6);
    write_reg(CFG_OFFSET, 32'd0);
    write_reg(CFG_WEIGHT, 32'h7FFF);
    for (int i = 0; i < 6; i++) send_item(ACT_LOAD, POS_W'(i), states[i]);
    send_item(ACT_LOAD, 12'hFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < 6; i++) send_item(ACT_QUERY, POS_W'(i), $urandom);
    send_item(ACT_QUERY, 12'd6, $urandom);
    send_item(ACT_QUERY, 12'hFFF, 32'hFFFF_FFFF);
    write_reg(CFG_NUM_SITES, 32'd1);
    send_item(ACT_QUERY, 12'd2, $urandom);
    write_reg(CFG_NUM_SITES, 32'd0);
    send_item(ACT_QUERY, 12'd3, $urandom);
    write_reg(CFG_NUM_SITES, 32'd63);
    send_item(ACT_QUERY, 12'd1, $urandom);
    write_reg(CFG_WEIGHT, 32'h8000);
    write_reg(CFG_OFFSET, 32'hFF_FFFF);
    send_item(ACT_QUERY, 12'd5, $urandom);
    send_item(ACT_QUERY, 12'hFFF, $urandom);
    write_reg(CFG_ENTRIES, 32'd0);
    send_item(ACT_QUERY, 12'd0, $urandom);
    // duplicate entry leaves the table unsorted
    write_reg(CFG_ENTRIES, 32'd6);
    send_item(ACT_LOAD, 12'd2, 32'd3);
    send_item(ACT_QUERY, 12'd1, $urandom);
  endtask

  // Full-size table, loaded only where the searches reach, with the saturating counts.
  task automatic test_full_table();
    logic [POS_W-1:0] qa, qb;
    full_prefix = $urandom;
    qa = POS_W'($urandom_range(6, 4094));
    qb = POS_W'($urandom_range(6, 4094));
    write_reg(CFG_NUM_SITES, 32'd3);
    write_reg(CFG_ENTRIES, 32'd4096);
    write_reg(CFG_OFFSET, $urandom & 32'h00FF_FFFF);
    write_reg(CFG_WEIGHT, $urandom & 32'hFFFF);
    query_full(qa);
    query_full(qb);
    query_full(12'd0);
    query_full(12'hFFF);
    write_reg(CFG_ENTRIES, 32'd8191);
    query_full(qa);
    query_full(12'hFFF);
    write_reg(CFG_NUM_SITES, 32'd63);
    query_full(12'hFFF);
    query_full(12'd0);
    write_reg(CFG_NUM_SITES, 32'd2);
    query_full(qb);
  endtask

  // Fixed-occupancy or sorted random bases, plus queries past the end and stray loads.
  task automatic test_random_hopping();
    int unsigned tsites, fill, avail, n, cnt, r;
    logic [WORD_W-1:0] prefix;
    longint unsigned acc, step;
    for (int ph = 0; ph < 6; ph++) begin
      tsites = $urandom_range(3, 10);
      fill = $urandom_range(1, tsites - 1);
      avail = 0;
      for (int c = 0; c < (1 << tsites); c++)
        if ($countones(c) == fill) avail++;
      n = $urandom_range(1, (avail < 40) ? avail : 40);
      no_gaps = (ph == 2);
      r = $urandom_range(0, 3);
      write_reg(CFG_NUM_SITES, (r == 0) ? $urandom_range(0, 63) : tsites);
      write_reg(CFG_ENTRIES, n);
      r = $urandom_range(0, 3);
      write_reg(CFG_OFFSET, (r == 0) ? 32'd0 : (r == 1) ? 32'hFF_FFFF : ($urandom & 32'hFF_FFFF));
      write_reg(CFG_WEIGHT, $urandom & 32'hFFFF);
      prefix = $urandom;
      if ($urandom_range(0, 4) == 0) begin
        step = 64'hFFFF_FFFF / (n + 1);
        acc = $urandom_range(0, 32'(step));
        for (int i = 0; i < n; i++) begin
          send_item(ACT_LOAD, POS_W'(i), acc[31:0]);
          acc += $urandom_range(1, 32'(step));
        end
      end else begin
        cnt = 0;
        for (int c = 0; c < (1 << tsites) && cnt < n; c++) begin
          if ($countones(c) == fill) begin
            send_item(ACT_LOAD, POS_W'(cnt), (prefix << tsites) | 32'(c));
            cnt++;
          end
        end
      end
      for (int k = 0; k < 35; k++) begin
        r = $urandom_range(0, 99);
        if (r < 70) send_item(ACT_QUERY, POS_W'($urandom_range(0, n - 1)), $urandom);
        else if (r < 80) send_item(ACT_QUERY, POS_W'($urandom_range(n, 4095)), $urandom);
        else if (r < 85) send_item(ACT_LOAD, POS_W'($urandom_range(0, n - 1)), $urandom);
        else send_item(ACT_LOAD, POS_W'($urandom_range(n, 4095)), $urandom);
      end
      no_gaps = 1'b0;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_small_table();
    test_full_table();
    test_random_hopping();
    drain(TAIL_CYCLES);
    if (mismatch_count == 0 && pending_entries.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
